// File: rtl/core/ticks_to_nanoseconds_core_macros.svh
// ----------------------------------------------------------------------------
// Tick-to-nanosecond core assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TICKS_TO_NANOSECONDS_CORE_MACROS_SVH
`define TICKS_TO_NANOSECONDS_CORE_MACROS_SVH

// Overlapping implication: cons checked in the same cycle as ante.
`define TNS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a delay given by the dly argument.
`define TNS_ASSERT_DLY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

// File: rtl/core/tns_pkg.sv
// ----------------------------------------------------------------------------
// Tick-to-nanosecond package
// Widths, constants and pipeline depths shared by the core and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tns_pkg;

    localparam int TICK_W = 64;
    localparam int FREQ_W = 40;
    localparam int NS_W   = 30;   // 1e9 fits in 30 bits
    localparam int KEEP_BITS = 33;
    localparam int SH_W   = 3;    // shift is 0..FREQ_W-1-KEEP_BITS

    localparam logic [NS_W-1:0]   NS_PER_SEC = 30'd1000000000;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 40'd1000000000;

    // Fraction quotient is below 2^NS_W, so the second divide needs NS_W steps.
    localparam int DIV1_STEPS = TICK_W;
    localparam int DIV2_STEPS = NS_W;

    // Accept edge to the edge at which the result beat is taken.
    localparam int LATENCY = DIV1_STEPS + DIV2_STEPS + 5;

endpackage

// File: rtl/core/ticks_to_nanoseconds_core.sv
// Path: first divider, stages A, B, C, second divider, output register.
// Throughput: one beat per cycle; busy is never raised.
// The set is two restoring dividers, one quotient bit per stage (64 + 30 stages).
// Reset: synchronous, active low; clears all valid bits, freq_hz returns to 1e9.
// The result strobe o_valid lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Tick-to-nanosecond converter
// Pipelined ticks / freq, whole part times 1e9 plus scaled fractional divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ticks_to_nanoseconds_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tns_pkg::TICK_W-1:0]      i_ticks,
    input  logic                            i_freq_we,
    input  logic [tns_pkg::FREQ_W-1:0]      i_freq_hz,
    output logic                            o_valid,
    output logic [tns_pkg::TICK_W-1:0]      o_nanoseconds
);

    localparam int TW = tns_pkg::TICK_W;
    localparam int FW = tns_pkg::FREQ_W;
    localparam int QW = tns_pkg::NS_W;
    localparam int D1 = tns_pkg::DIV1_STEPS;
    localparam int D2 = tns_pkg::DIV2_STEPS;
    localparam int RW = tns_pkg::KEEP_BITS + 1;   // shifted remainder width

    // Frequency register
    logic [FW-1:0] r_freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= tns_pkg::FREQ_RESET;
        end else if (i_freq_we) begin
            r_freq <= i_freq_hz;
        end
    end

    assign busy = 1'b0;

    // First divider: ticks / freq, quotient bits shift into num
    logic          r_d1_v   [0:D1];
    logic [FW-1:0] r_d1_rem [0:D1];
    logic [TW-1:0] r_d1_num [0:D1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v[0] <= 1'b0;
        end else begin
            r_d1_v[0] <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1_rem[0] <= '0;
        r_d1_num[0] <= i_ticks;
    end

    for (genvar s = 1; s <= D1; s++) begin : g_div1
        logic [FW:0]   t;
        logic          q;
        logic [FW-1:0] n_rem;

        always_comb begin
            t = {r_d1_rem[s-1], r_d1_num[s-1][TW-1]};
            q = (t >= {1'b0, r_freq});
            n_rem = q ? FW'(t - {1'b0, r_freq}) : t[FW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_v[s] <= 1'b0;
            end else begin
                r_d1_v[s] <= r_d1_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_d1_rem[s] <= n_rem;
            r_d1_num[s] <= {r_d1_num[s-1][TW-2:0], q};
        end
    end

    // Stage A: normalize remainder and frequency
    logic [tns_pkg::SH_W-1:0] n_sh;
    logic                     r_a_v;
    logic [TW-1:0]            r_a_q;
    logic [RW-1:0]            r_a_rem;
    logic [FW-1:0]            r_a_fs;

    always_comb begin
        n_sh = '0;
        for (int k = tns_pkg::KEEP_BITS + 1; k < FW; k++) begin
            if (r_d1_rem[D1][k]) begin
                n_sh = tns_pkg::SH_W'(k - tns_pkg::KEEP_BITS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= r_d1_v[D1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_q   <= r_d1_num[D1];
        r_a_rem <= RW'(r_d1_rem[D1] >> n_sh);
        r_a_fs  <= r_freq >> n_sh;
    end

    // Stage B: products by 1e9 (whole part split into 32-bit halves)
    logic          r_b_v;
    logic [TW-1:0] r_b_plo;
    logic [31:0]   r_b_phi;
    logic [TW-1:0] r_b_pfr;
    logic [FW-1:0] r_b_fs;
    logic [61:0]   n_phi_full;

    assign n_phi_full = 62'(r_a_q[TW-1:32]) * 62'(tns_pkg::NS_PER_SEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_plo <= TW'(r_a_q[31:0]) * TW'(tns_pkg::NS_PER_SEC);
        r_b_phi <= n_phi_full[31:0];
        r_b_pfr <= TW'(r_a_rem) * TW'(tns_pkg::NS_PER_SEC);
        r_b_fs  <= r_a_fs;
    end

    // Stage C: whole-second sum, load second divider
    logic          r_d2_v     [0:D2];
    logic [FW-1:0] r_d2_rem   [0:D2];
    logic [QW-1:0] r_d2_num   [0:D2];
    logic [FW-1:0] r_d2_fs    [0:D2];
    logic [TW-1:0] r_d2_whole [0:D2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_v[0] <= 1'b0;
        end else begin
            r_d2_v[0] <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d2_rem[0]   <= FW'(r_b_pfr[TW-1:QW]);
        r_d2_num[0]   <= r_b_pfr[QW-1:0];
        r_d2_fs[0]    <= r_b_fs;
        r_d2_whole[0] <= r_b_plo + {r_b_phi, 32'd0};
    end

    // Second divider: (rem_s * 1e9) / f_s
    for (genvar s = 1; s <= D2; s++) begin : g_div2
        logic [FW:0]   t;
        logic          q;
        logic [FW-1:0] n_rem;

        always_comb begin
            t = {r_d2_rem[s-1], r_d2_num[s-1][QW-1]};
            q = (t >= {1'b0, r_d2_fs[s-1]});
            n_rem = q ? FW'(t - {1'b0, r_d2_fs[s-1]}) : t[FW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_v[s] <= 1'b0;
            end else begin
                r_d2_v[s] <= r_d2_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_d2_rem[s]   <= n_rem;
            r_d2_num[s]   <= {r_d2_num[s-1][QW-2:0], q};
            r_d2_fs[s]    <= r_d2_fs[s-1];
            r_d2_whole[s] <= r_d2_whole[s-1];
        end
    end

    // Output register; zero frequency saturates
    logic          r_out_v;
    logic [TW-1:0] r_out_ns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_d2_v[D2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_freq == '0) begin
            r_out_ns <= '1;
        end else begin
            r_out_ns <= r_d2_whole[D2] + TW'(r_d2_num[D2]);
        end
    end

    assign o_valid       = r_out_v;
    assign o_nanoseconds = r_out_ns;

endmodule

// File: rtl/core/tns_checker.sv
// ----------------------------------------------------------------------------
// Tick-to-nanosecond checker
// Port-level checks on beat count and fixed latency of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ticks_to_nanoseconds_core_macros.svh"

module tns_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid
);

    // Every accepted beat yields a result after the fixed latency
    `TNS_ASSERT_DLY(a_lat_hit, start && !busy, tns_pkg::LATENCY, o_valid, "result beat missing")

    // No result appears without a matching accepted beat
    `TNS_ASSERT_DLY(a_lat_none, !(start && !busy), tns_pkg::LATENCY, !o_valid, "spurious result")

    // The pipeline never pushes back
    `TNS_ASSERT_IMP(a_no_busy, 1'b1, !busy, "busy raised")

endmodule

bind ticks_to_nanoseconds_core tns_checker u_tns_checker (.*);

// File: dv/ticks_to_nanoseconds_core_test.sv
// ----------------------------------------------------------------------------
// Tick-to-nanosecond core testbench
// Sends tick counts under several counter frequencies (reset value, extremes,
// zero, fixed and random), back to back or with random gaps, predicts each
// nanosecond value and checks every result beat in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ticks_to_nanoseconds_core_test;

    localparam int WATCHDOG_CYCLES = 4 * tns_pkg::LATENCY + 400;
    localparam logic [tns_pkg::FREQ_W-1:0] FREQ_MAX = {tns_pkg::FREQ_W{1'b1}};

    // Scoreboard: tracks the frequency register and pending nanosecond values
    class ns_scoreboard;
        bit [tns_pkg::FREQ_W-1:0] freq = tns_pkg::FREQ_RESET;
        bit [63:0]                ns_queue[$];
        int                       errors = 0;

        function bit [63:0] convert(bit [63:0] ticks);
            bit [63:0] f, whole, rem, ns_per_sec;
            int        msb, sh;
            ns_per_sec = 64'(tns_pkg::NS_PER_SEC);
            f = 64'(freq);
            // zero frequency saturates the divider
            if (f == 0) return '1;
            whole = ticks / f;
            rem   = ticks % f;
            msb   = -1;
            for (int i = 0; i < 64; i++) if (rem[i]) msb = i;
            sh  = (msb > tns_pkg::KEEP_BITS) ? msb - tns_pkg::KEEP_BITS : 0;
            rem = rem >> sh;
            f   = f >> sh;
            return whole * ns_per_sec + (rem * ns_per_sec) / f;
        endfunction

        function void note_ticks(bit [63:0] ticks);
            ns_queue.push_back(convert(ticks));
        endfunction

        function void check_ns(bit [63:0] actual);
            bit [63:0] exp_ns;
            if (ns_queue.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, actual);
                errors++;
                return;
            end
            exp_ns = ns_queue.pop_front();
            if (exp_ns !== actual) begin
                $display("%0t: nanoseconds mismatch, expected %h, actual %h",
                         $time, exp_ns, actual);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [tns_pkg::TICK_W-1:0] i_ticks = '0;
    logic                       i_freq_we = 1'b0;
    logic [tns_pkg::FREQ_W-1:0] i_freq_hz = '0;
    logic                       o_valid;
    logic [tns_pkg::TICK_W-1:0] o_nanoseconds;

    ns_scoreboard sb = new();
    int           idle_cycles = 0;
    bit           no_gaps = 1'b0;

    ticks_to_nanoseconds_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_ticks       (i_ticks),
        .i_freq_we     (i_freq_we),
        .i_freq_hz     (i_freq_hz),
        .o_valid       (o_valid),
        .o_nanoseconds (o_nanoseconds)
    );

    always #1 i_clk = ~i_clk;

    // Monitor: config writes, accepted beats, result beats, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_freq_we) begin
                sb.freq = i_freq_hz;
            end
            if (start && !busy) begin
                sb.note_ticks(i_ticks);
            end
            if (o_valid) begin
                sb.check_ns(o_nanoseconds);
            end
            if (i_freq_we || (start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_freq(logic [tns_pkg::FREQ_W-1:0] value);
        @(negedge i_clk);
        i_freq_we <= 1'b1;
        i_freq_hz <= value;
        @(negedge i_clk);
        i_freq_we <= 1'b0;
    endtask

    // One input beat: random gap, then hold start until the beat is taken
    task automatic send_ticks(logic [tns_pkg::TICK_W-1:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_ticks <= value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.ns_queue.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [tns_pkg::TICK_W-1:0] rand_ticks();
        logic [63:0] f;
        f = 64'(sb.freq);
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 100000));
            2: return f * $urandom_range(0, 5000) + $urandom_range(0, 3) - 64'd2;
            3: return {$urandom, $urandom} >> $urandom_range(0, 63);
            4: return $urandom_range(0, 1) ? '1 : '0;
            default: return f * {$urandom, $urandom} - 64'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic run_phase(logic [tns_pkg::FREQ_W-1:0] freq, int count);
        wait_drained();
        write_freq(freq);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            send_ticks(rand_ticks());
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset frequency, field extremes, remainder edges
        send_ticks('0);
        send_ticks(64'd1);
        send_ticks(64'd999999999);
        send_ticks(64'd1000000000);
        send_ticks(64'd1000000001);
        send_ticks('1);
        send_ticks(64'h8000_0000_0000_0000);
        send_ticks(64'h5555_5555_5555_5555);
        send_ticks(64'hAAAA_AAAA_AAAA_AAAA);
        // whole part overflows 2^64 at 1 Hz
        run_phase(40'd1, 4);
        send_ticks('1);
        // maximum frequency: large remainder, shifted path
        run_phase(FREQ_MAX, 0);
        send_ticks(64'(FREQ_MAX) - 64'd1);
        send_ticks(64'h0000_0002_0000_0000);
        send_ticks('1);
        send_ticks(64'(FREQ_MAX));
        // zero frequency saturates
        run_phase('0, 0);
        send_ticks('0);
        send_ticks('1);
        send_ticks(64'd12345);

        // random phases, including extremes again
        run_phase(tns_pkg::FREQ_RESET, 100);
        run_phase(40'd1, 60);
        run_phase(FREQ_MAX, 120);
        run_phase(40'd3, 60);
        run_phase('0, 20);
        run_phase(40'd19200000, 100);
        run_phase(40'h2_0000_0001, 100);
        for (int p = 0; p < 5; p++)
            run_phase(40'({$urandom, $urandom}) | 40'd1, 60);

        wait_drained();
        repeat (tns_pkg::LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: ticks_to_nanoseconds_core.f
+incdir+rtl/core
rtl/core/tns_pkg.sv
rtl/core/ticks_to_nanoseconds_core.sv
rtl/core/tns_checker.sv
dv/ticks_to_nanoseconds_core_test.sv
